@@ rtl/trme_pkg.sv @@
package trme_pkg;

   localparam int DEPTH = 64;
   localparam int AW    = $clog2(DEPTH);
   localparam int DW    = 32;
   localparam int CW    = AW + 1;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_MERGE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] CSR_FIRST_START = 2'd0;
   localparam logic [1:0] CSR_FIRST_END   = 2'd1;
   localparam logic [1:0] CSR_SECOND_END  = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_COPY,
      ST_READ,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic [1:0]           command;
      logic [AW-1:0]        index;
      logic signed [DW-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] value_res;
      logic [AW-1:0]        index_res;
      logic                 last;
      logic                 status;
   } rsp_type;

   typedef struct packed {
      logic          en;
      logic [AW-1:0] addr;
      logic [DW-1:0] data;
   } wr_type;

   typedef struct packed {
      logic left_ok;
      logic right_ok;
   } pick_ctl_type;

endpackage

@@ rtl/trme_store.sv @@
// Element store: one write port, two registered read ports.
module trme_store (
   input  logic                         clock,
   input  trme_pkg::wr_type             wr,
   input  logic [trme_pkg::AW-1:0]      rd_a_addr,
   input  logic [trme_pkg::AW-1:0]      rd_b_addr,
   output logic [trme_pkg::DW-1:0]      rd_a_data,
   output logic [trme_pkg::DW-1:0]      rd_b_data
);

   logic [trme_pkg::DW-1:0] mem_ff [trme_pkg::DEPTH];
   logic [trme_pkg::DW-1:0] rd_a_ff;
   logic [trme_pkg::DW-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

@@ rtl/trme_mbuf.sv @@
// Merge buffer: one write port, one registered read port.
// A read of the entry being written returns the new data.
module trme_mbuf (
   input  logic                         clock,
   input  trme_pkg::wr_type             wr,
   input  logic [trme_pkg::AW-1:0]      rd_addr,
   output logic [trme_pkg::DW-1:0]      rd_data
);

   logic [trme_pkg::DW-1:0] mem_ff [trme_pkg::DEPTH];
   logic [trme_pkg::DW-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_ff <= (wr.en && (wr.addr == rd_addr)) ? wr.data : mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

@@ rtl/trme_pick.sv @@
// Compare and select: left wins ties (stable merge).
module trme_pick (
   input  trme_pkg::pick_ctl_type       ctl,
   input  logic [trme_pkg::DW-1:0]      left_val,
   input  logic [trme_pkg::DW-1:0]      right_val,
   output logic                         take_left,
   output logic [trme_pkg::DW-1:0]      pick_val
);

   logic left_le;

   assign left_le   = $signed(left_val) <= $signed(right_val);
   assign take_left = ctl.left_ok && (!ctl.right_ok || left_le);
   assign pick_val  = take_left ? left_val : right_val;

endmodule

@@ rtl/two_run_merge_engine_core.sv @@
// Two-run merge engine.
// Holds a 64-entry store of signed Q16.16 values and merges two adjacent
// sorted runs in place.
// Request channel (req_valid/req_stall/req_data): command 0 writes value at
// index (no result), command 1 merges [first_start..first_end] with
// [first_end+1..second_end], command 2 reads one entry, command 3 is dropped.
// Result channel (rsp_valid/rsp_stall/rsp_data): one transfer per merged
// element in order with its new index, last set on the final one; a read gives
// one transfer. A bad run description gives a single transfer with status set.
// CSR port: first_start, first_end, second_end, which the user must write only
// while idle; the block itself does not enforce it. A merge runs a compare
// pass (one comparator, two store read ports) into the merge buffer, then a
// write-back through the single store write port, which pauses while the
// receiver stalls.
// req_stall is high for the whole of a merge or read.
// Reset (synchronous) returns to idle, clears the registers and drops rsp_valid;
// store contents are undefined until written.
// A stalled result sits in the output register; write-back pauses behind it.
module two_run_merge_engine_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  trme_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output trme_pkg::rsp_type        rsp_data,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [trme_pkg::AW-1:0]  csr_wdata
);

   // run description registers
   logic [trme_pkg::AW-1:0] first_start_ff;
   logic [trme_pkg::AW-1:0] first_end_ff;
   logic [trme_pkg::AW-1:0] second_end_ff;

   trme_pkg::state_type state_ff, state_in;

   // left cursor, right cursor and output count; one bit wider to pass the end
   logic [trme_pkg::CW-1:0] s_ff, s_in;
   logic [trme_pkg::CW-1:0] t_ff, t_in;
   logic [trme_pkg::CW-1:0] k_ff, k_in;

   logic              rsp_valid_ff, rsp_valid_in;
   trme_pkg::rsp_type rsp_ff, rsp_in;

   logic                    req_accept;
   logic                    out_free;
   logic                    runs_ok;
   logic [trme_pkg::AW-1:0] span;        // second_end - first_start
   logic                    merge_done;
   logic                    copy_last;

   trme_pkg::wr_type        store_wr;
   trme_pkg::wr_type        mbuf_wr;
   logic [trme_pkg::DW-1:0] store_a;
   logic [trme_pkg::DW-1:0] store_b;
   logic [trme_pkg::DW-1:0] mbuf_rd;

   trme_pkg::pick_ctl_type  pick_ctl;
   logic                    take_left;
   logic [trme_pkg::DW-1:0] pick_val;

   assign req_stall  = (state_ff != trme_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign runs_ok    = (first_start_ff <= first_end_ff) && (first_end_ff <= second_end_ff);
   assign span       = second_end_ff - first_start_ff;
   assign merge_done = (k_ff[trme_pkg::AW-1:0] == span);
   assign copy_last  = (k_ff[trme_pkg::AW-1:0] == span);

   assign pick_ctl.left_ok  = (s_ff <= {1'b0, first_end_ff});
   assign pick_ctl.right_ok = (t_ff <= {1'b0, second_end_ff});

   trme_store u_store (
      .clock     (clock),
      .wr        (store_wr),
      .rd_a_addr (s_in[trme_pkg::AW-1:0]),
      .rd_b_addr (t_in[trme_pkg::AW-1:0]),
      .rd_a_data (store_a),
      .rd_b_data (store_b)
   );

   trme_mbuf u_mbuf (
      .clock   (clock),
      .wr      (mbuf_wr),
      .rd_addr (k_in[trme_pkg::AW-1:0]),
      .rd_data (mbuf_rd)
   );

   trme_pick u_pick (
      .ctl       (pick_ctl),
      .left_val  (store_a),
      .right_val (store_b),
      .take_left (take_left),
      .pick_val  (pick_val)
   );

   // CSR writes; unused index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         first_start_ff <= '0;
         first_end_ff   <= '0;
         second_end_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            trme_pkg::CSR_FIRST_START: first_start_ff <= csr_wdata;
            trme_pkg::CSR_FIRST_END:   first_end_ff   <= csr_wdata;
            trme_pkg::CSR_SECOND_END:  second_end_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         trme_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.command)
                  trme_pkg::CMD_MERGE: state_in = runs_ok ? trme_pkg::ST_MERGE
                                                          : trme_pkg::ST_ERR;
                  trme_pkg::CMD_READ:  state_in = trme_pkg::ST_READ;
                  default:             state_in = trme_pkg::ST_IDLE;
               endcase
            end
         end
         trme_pkg::ST_MERGE: begin
            if (merge_done) state_in = trme_pkg::ST_COPY;
         end
         trme_pkg::ST_COPY: begin
            if (out_free && copy_last) state_in = trme_pkg::ST_IDLE;
         end
         trme_pkg::ST_READ,
         trme_pkg::ST_ERR: begin
            if (out_free) state_in = trme_pkg::ST_IDLE;
         end
         default: state_in = trme_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      s_in         = s_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      store_wr     = '0;
      mbuf_wr      = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         trme_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.command)
                  trme_pkg::CMD_WRITE: begin
                     store_wr.en   = 1'b1;
                     store_wr.addr = req_data.index;
                     store_wr.data = req_data.value;
                  end
                  trme_pkg::CMD_MERGE: begin
                     s_in = {1'b0, first_start_ff};
                     t_in = {1'b0, first_end_ff} + trme_pkg::CW'(1);
                     k_in = '0;
                  end
                  trme_pkg::CMD_READ: begin
                     s_in = {1'b0, req_data.index};
                  end
                  default: ;
               endcase
            end
         end
         trme_pkg::ST_MERGE: begin
            // one element per cycle into the buffer
            mbuf_wr.en   = 1'b1;
            mbuf_wr.addr = k_ff[trme_pkg::AW-1:0];
            mbuf_wr.data = pick_val;
            if (take_left) begin
               s_in = s_ff + trme_pkg::CW'(1);
            end else begin
               t_in = t_ff + trme_pkg::CW'(1);
            end
            k_in = merge_done ? '0 : k_ff + trme_pkg::CW'(1);
         end
         trme_pkg::ST_COPY: begin
            if (out_free) begin
               store_wr.en      = 1'b1;
               store_wr.addr    = first_start_ff + k_ff[trme_pkg::AW-1:0];
               store_wr.data    = mbuf_rd;
               rsp_in.value_res = mbuf_rd;
               rsp_in.index_res = first_start_ff + k_ff[trme_pkg::AW-1:0];
               rsp_in.last      = copy_last;
               rsp_in.status    = trme_pkg::STATUS_OK;
               rsp_valid_in     = 1'b1;
               k_in             = k_ff + trme_pkg::CW'(1);
            end
         end
         trme_pkg::ST_READ: begin
            if (out_free) begin
               rsp_in.value_res = store_a;
               rsp_in.index_res = s_ff[trme_pkg::AW-1:0];
               rsp_in.last      = 1'b1;
               rsp_in.status    = trme_pkg::STATUS_OK;
               rsp_valid_in     = 1'b1;
            end
         end
         trme_pkg::ST_ERR: begin
            if (out_free) begin
               rsp_in.value_res = '0;
               rsp_in.index_res = '0;
               rsp_in.last      = 1'b1;
               rsp_in.status    = trme_pkg::STATUS_ERR;
               rsp_valid_in     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trme_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s_ff         <= '0;
         t_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s_ff         <= s_in;
         t_ff         <= t_in;
         k_ff         <= k_in;
      end
   end

   // output payload needs no reset
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/trme_check.sv @@
module trme_check (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input trme_pkg::rsp_type  rsp_data
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   // error result is a lone, zeroed transfer
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.last && (rsp_data.index_res == '0) && (rsp_data.value_res == '0))
      else $error("malformed error result");

   // while a non-final merge result is on offer the block is still busy
   a_busy_mid_merge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("request taken during merge write-back");

endmodule

bind two_run_merge_engine_core trme_check u_trme_check (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ test/run_merge_checker.sv @@
module run_merge_checker
   import trme_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [AW-1:0]     csr_wdata,
   output int                failures,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [DW-1:0] shadow_store [DEPTH];
   logic [AW-1:0]        run_first_start;
   logic [AW-1:0]        run_first_end;
   logic [AW-1:0]        run_second_end;
   rsp_type              expected_elements [$];

   function automatic void expect_element(logic signed [DW-1:0] value, logic [AW-1:0] index,
                                          logic last, logic status);
      rsp_type item;
      item.value_res = value;
      item.index_res = index;
      item.last      = last;
      item.status    = status;
      expected_elements.push_back(item);
   endfunction

   // stable two-run merge, written back in place
   task automatic predict_merge();
      logic signed [DW-1:0] merged [$];
      int s;
      int t;
      int fe;
      int se;
      if (!(run_first_start <= run_first_end && run_first_end <= run_second_end)) begin
         expect_element('0, '0, 1'b1, STATUS_ERR);
         return;
      end
      s  = int'(run_first_start);
      fe = int'(run_first_end);
      se = int'(run_second_end);
      t  = fe + 1;
      while (s <= fe || t <= se) begin
         // left run wins a tie
         if (t > se || (s <= fe && shadow_store[s] <= shadow_store[t])) begin
            merged.push_back(shadow_store[s]);
            s++;
         end else begin
            merged.push_back(shadow_store[t]);
            t++;
         end
      end
      foreach (merged[k]) begin
         shadow_store[int'(run_first_start) + k] = merged[k];
         expect_element(merged[k], AW'(int'(run_first_start) + k),
                        k == merged.size() - 1, STATUS_OK);
      end
   endtask

   task automatic compare_field(input string field, input logic [DW-1:0] want,
                                input logic [DW-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         run_first_start = '0;
         run_first_end   = '0;
         run_second_end  = '0;
         expected_elements.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_elements.size() == 0) begin
               $error("result transfer with nothing expected: value_res 0x%0h index_res %0d",
                      rsp_data.value_res, rsp_data.index_res);
               failures++;
            end else begin
               want = expected_elements.pop_front();
               compare_field("value_res", want.value_res, rsp_data.value_res);
               compare_field("index_res", DW'(want.index_res), DW'(rsp_data.index_res));
               compare_field("last", DW'(want.last), DW'(rsp_data.last));
               compare_field("status", DW'(want.status), DW'(rsp_data.status));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FIRST_START: run_first_start = csr_wdata;
               CSR_FIRST_END:   run_first_end   = csr_wdata;
               CSR_SECOND_END:  run_second_end  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_data.command)
               CMD_WRITE: shadow_store[req_data.index] = req_data.value;
               CMD_MERGE: predict_merge();
               CMD_READ:  expect_element(shadow_store[req_data.index], req_data.index,
                                         1'b1, STATUS_OK);
               default: ;
            endcase
         end
      end
      pending = expected_elements.size();
   end

endmodule

@@ test/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import trme_pkg::*;

   // command code the block drops without a result
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int ITEM_TARGET   = 210;     // counted input transfers, ignored ones excluded
   localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;       // a write gives no result; let it finish
   localparam int CYCLE_LIMIT   = 400000;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_wr_en;
   logic [1:0]    csr_index;
   logic [AW-1:0] csr_wdata;

   int pending;
   int failures;
   int items_sent;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int cycles        = 0;

   two_run_merge_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // watches both channels and the CSR port, predicts and compares
   run_merge_checker merge_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: a hung block or a lost result ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL two_run_merge_engine_core");
         $finish;
      end
   end

   // Result side. Random stall at the current rate, unless a hold-off has been
   // asked for, in which case stall solidly for HOLD_CYCLES so the block backs up.
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic req_type make_req(logic [1:0] cmd, int idx, logic [DW-1:0] val);
      req_type r;
      r.command = cmd;
      r.index   = AW'(idx);
      r.value   = val;
      return r;
   endfunction

   // element values: extremes, sign boundary, otherwise anything
   function automatic logic [DW-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // One request transfer. Called and returns on a falling edge; valid stays
   // high afterwards, so anyone who then waits must drop it first.
   task automatic offer(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.command != CMD_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // drain: every expected result in, then a settling wait of SETTLE_CYCLES
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // only ever called with the block idle
   task automatic program_runs(input int fs, input int fe, input int se);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_FIRST_START;
      csr_wdata <= AW'(fs);
      @(negedge clock);
      csr_index <= CSR_FIRST_END;
      csr_wdata <= AW'(fe);
      @(negedge clock);
      csr_index <= CSR_SECOND_END;
      csr_wdata <= AW'(se);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // load an ascending run; sometimes from a tiny pool so ties are common
   task automatic write_run(input int first, input int count);
      int vals [$];
      int mode;
      mode = $urandom_range(2);
      for (int i = 0; i < count; i++) begin
         if (mode == 0) vals.push_back((int'($urandom_range(4)) - 2) * 65536);
         else           vals.push_back(int'(pick_value()));
      end
      vals.sort();
      foreach (vals[i]) offer(make_req(CMD_WRITE, first + i, vals[i]));
   endtask

   initial begin
      int fs;
      int fe;
      int se;
      int left_len;
      int right_len;
      int choice;

      req_valid     = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_FIRST_START;
      csr_wdata     = '0;
      items_sent    = 0;
      send_idle_pct = 9;
      recv_idle_pct = 46;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // ---- directed part: only entries written here are ever read ----
      // left run: min, 1.0, max; right run: min, -1.0, 1.0 (ties across runs)
      offer(make_req(CMD_WRITE, 0, 32'h8000_0000));
      offer(make_req(CMD_WRITE, 1, 32'h0001_0000));
      offer(make_req(CMD_WRITE, 2, 32'h7FFF_FFFF));
      offer(make_req(CMD_WRITE, 3, 32'h8000_0000));
      offer(make_req(CMD_WRITE, 4, 32'hFFFF_0000));
      offer(make_req(CMD_WRITE, 5, 32'h0001_0000));
      offer(make_req(CMD_READ, 0, '0));
      offer(make_req(CMD_READ, 5, '0));
      // registers still at reset: one-element merge of entry 0
      offer(make_req(CMD_MERGE, 0, '0));
      settle();
      program_runs(0, 2, 5);
      offer(make_req(CMD_MERGE, 0, '0));
      // empty right run: left run comes out unchanged
      settle();
      program_runs(0, 5, 5);
      offer(make_req(CMD_MERGE, 0, '0));
      // bad run descriptions: start past end, end past second end, extremes
      settle();
      program_runs(3, 2, 5);
      offer(make_req(CMD_MERGE, 0, '0));
      settle();
      program_runs(0, 4, 3);
      offer(make_req(CMD_MERGE, 0, '0));
      settle();
      program_runs(63, 0, 0);
      offer(make_req(CMD_MERGE, 0, '0));
      settle();
      program_runs(0, 63, 62);
      offer(make_req(CMD_MERGE, 0, '0));
      offer(make_req(CMD_WRITE, 63, 32'hAAAA_AAAA));
      offer(make_req(CMD_WRITE, 6, 32'h5555_5555));
      offer(make_req(CMD_READ, 63, '0));
      offer(make_req(CMD_UNUSED, 63, $urandom));
      offer(make_req(CMD_READ, 2, '0));

      // ---- fill the whole store as two sorted halves, then a full merge ----
      // The receiver holds off for a long stretch while further requests are
      // offered, so the output backs up and the request side stalls.
      settle();
      program_runs(0, 31, 63);
      write_run(0, 32);
      write_run(32, 32);
      hold_requests <= hold_requests + 1;
      offer(make_req(CMD_MERGE, 0, '0));
      offer(make_req(CMD_READ, $urandom_range(63), '0));
      offer(make_req(CMD_WRITE, $urandom_range(63), pick_value()));
      offer(make_req(CMD_READ, $urandom_range(63), '0));

      // ---- random part: every entry is now written ----
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 175) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end else if (items_sent >= 130) begin
            send_idle_pct <= 46;
            recv_idle_pct <= 9;
         end
         choice = $urandom_range(99);
         if (choice < 60) begin
            if ($urandom_range(9) == 0) begin
               // wide merge over most of the store, existing contents
               fs = $urandom_range(3);
               se = 63 - $urandom_range(3);
               fe = $urandom_range(se, fs);
               settle();
               program_runs(fs, fe, se);
               offer(make_req(CMD_MERGE, 0, '0));
            end else begin
               // well-formed: short sorted runs loaded, then merged
               left_len  = $urandom_range(6, 1);
               right_len = $urandom_range(6);
               fs = $urandom_range(64 - left_len - right_len);
               fe = fs + left_len - 1;
               se = fe + right_len;
               settle();
               program_runs(fs, fe, se);
               write_run(fs, left_len);
               write_run(fe + 1, right_len);
               offer(make_req(CMD_MERGE, $urandom_range(63), $urandom));
               if ($urandom_range(1)) offer(make_req(CMD_READ, $urandom_range(se, fs), '0));
            end
         end else if (choice < 72) begin
            // broken run description: must give a single error transfer
            if ($urandom_range(1)) begin
               fe = $urandom_range(62);
               fs = $urandom_range(63, fe + 1);
               se = $urandom_range(63);
            end else begin
               se = $urandom_range(62);
               fe = $urandom_range(63, se + 1);
               fs = $urandom_range(fe);
            end
            settle();
            program_runs(fs, fe, se);
            offer(make_req(CMD_MERGE, 0, '0));
         end else if (choice < 88) begin
            // loose writes and reads anywhere
            repeat ($urandom_range(4, 1)) begin
               offer(make_req($urandom_range(1) ? CMD_WRITE : CMD_READ,
                              $urandom_range(63), pick_value()));
            end
         end else if (choice < 95) begin
            // unsorted content in the runs; merged by the same walk
            fs = $urandom_range(56);
            se = fs + $urandom_range(7);
            fe = $urandom_range(se, fs);
            settle();
            program_runs(fs, fe, se);
            repeat ($urandom_range(4)) begin
               offer(make_req(CMD_WRITE, $urandom_range(se, fs), pick_value()));
            end
            offer(make_req(CMD_MERGE, 0, '0));
         end else begin
            // dropped commands, then merge again with whatever is programmed
            repeat ($urandom_range(3, 1)) begin
               offer(make_req(CMD_UNUSED, $urandom_range(63), $urandom));
            end
            offer(make_req(CMD_MERGE, 0, '0));
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (failures == 0) begin
         $display("PASS two_run_merge_engine_core");
      end else begin
         $display("FAIL two_run_merge_engine_core");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/trme_pkg.sv
rtl/trme_store.sv
rtl/trme_mbuf.sv
rtl/trme_pick.sv
rtl/two_run_merge_engine_core.sv
rtl/trme_check.sv
test/run_merge_checker.sv
test/testbench.sv
